### sv/dtgd_pkg.sv
// ----------------------------------------------------------------------------
// dtgd_pkg: shared types and constants of the distance-to-gamma dimmer
// Holds the sequencer state type, the divider request bundle, the register
// map and the fixed gamma table.
// ----------------------------------------------------------------------------
package dtgd_pkg;

    localparam int SMP_W = 10;   // sample, limit and mean width
    localparam int BRT_W = 8;    // brightness width
    localparam int DTY_W = 16;   // duty width
    localparam int DVD_W = 18;   // divider dividend width, holds 1023 * 255
    localparam int DVS_W = 10;   // divider divisor width

    localparam logic [SMP_W-1:0] NEAR_RESET  = 10'd100;
    localparam logic [SMP_W-1:0] FAR_RESET   = 10'd240;
    localparam logic [BRT_W-1:0] FULL_BRIGHT = 8'd255;

    // Register select taken from paddr[2].
    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_AVG,
        S_BRT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    localparam logic [DTY_W-1:0] GAMMA_ROM [256] = '{
        16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd2, 16'd3,
        16'd4, 16'd6, 16'd8, 16'd10, 16'd13, 16'd16, 16'd19, 16'd24,
        16'd28, 16'd33, 16'd39, 16'd46, 16'd53, 16'd60, 16'd69, 16'd78,
        16'd88, 16'd98, 16'd110, 16'd122, 16'd135, 16'd149, 16'd164, 16'd179,
        16'd196, 16'd214, 16'd232, 16'd252, 16'd273, 16'd295, 16'd317, 16'd341,
        16'd366, 16'd393, 16'd420, 16'd449, 16'd478, 16'd510, 16'd542, 16'd575,
        16'd610, 16'd647, 16'd684, 16'd723, 16'd764, 16'd806, 16'd849, 16'd894,
        16'd940, 16'd988, 16'd1037, 16'd1088, 16'd1140, 16'd1194, 16'd1250, 16'd1307,
        16'd1366, 16'd1427, 16'd1489, 16'd1553, 16'd1619, 16'd1686, 16'd1756, 16'd1827,
        16'd1900, 16'd1975, 16'd2051, 16'd2130, 16'd2210, 16'd2293, 16'd2377, 16'd2463,
        16'd2552, 16'd2642, 16'd2734, 16'd2829, 16'd2925, 16'd3024, 16'd3124, 16'd3227,
        16'd3332, 16'd3439, 16'd3548, 16'd3660, 16'd3774, 16'd3890, 16'd4008, 16'd4128,
        16'd4251, 16'd4376, 16'd4504, 16'd4634, 16'd4766, 16'd4901, 16'd5038, 16'd5177,
        16'd5319, 16'd5464, 16'd5611, 16'd5760, 16'd5912, 16'd6067, 16'd6224, 16'd6384,
        16'd6546, 16'd6711, 16'd6879, 16'd7049, 16'd7222, 16'd7397, 16'd7576, 16'd7757,
        16'd7941, 16'd8128, 16'd8317, 16'd8509, 16'd8704, 16'd8902, 16'd9103, 16'd9307,
        16'd9514, 16'd9723, 16'd9936, 16'd10151, 16'd10370, 16'd10591, 16'd10816, 16'd11043,
        16'd11274, 16'd11507, 16'd11744, 16'd11984, 16'd12227, 16'd12473, 16'd12722, 16'd12975,
        16'd13230, 16'd13489, 16'd13751, 16'd14017, 16'd14285, 16'd14557, 16'd14833, 16'd15111,
        16'd15393, 16'd15678, 16'd15967, 16'd16259, 16'd16554, 16'd16853, 16'd17155, 16'd17461,
        16'd17770, 16'd18083, 16'd18399, 16'd18719, 16'd19042, 16'd19369, 16'd19700, 16'd20034,
        16'd20372, 16'd20713, 16'd21058, 16'd21407, 16'd21759, 16'd22115, 16'd22475, 16'd22838,
        16'd23206, 16'd23577, 16'd23952, 16'd24330, 16'd24713, 16'd25099, 16'd25489, 16'd25884,
        16'd26282, 16'd26683, 16'd27089, 16'd27499, 16'd27913, 16'd28330, 16'd28752, 16'd29178,
        16'd29608, 16'd30041, 16'd30479, 16'd30921, 16'd31367, 16'd31818, 16'd32272, 16'd32730,
        16'd33193, 16'd33660, 16'd34131, 16'd34606, 16'd35085, 16'd35569, 16'd36057, 16'd36549,
        16'd37046, 16'd37547, 16'd38052, 16'd38561, 16'd39075, 16'd39593, 16'd40116, 16'd40643,
        16'd41175, 16'd41711, 16'd42251, 16'd42796, 16'd43346, 16'd43899, 16'd44458, 16'd45021,
        16'd45588, 16'd46161, 16'd46737, 16'd47319, 16'd47905, 16'd48495, 16'd49091, 16'd49691,
        16'd50295, 16'd50905, 16'd51519, 16'd52138, 16'd52761, 16'd53390, 16'd54023, 16'd54661,
        16'd55303, 16'd55951, 16'd56604, 16'd57261, 16'd57923, 16'd58590, 16'd59262, 16'd59939,
        16'd60621, 16'd61308, 16'd62000, 16'd62697, 16'd63399, 16'd64106, 16'd64818, 16'd65535
    };

endpackage

### sv/dtgd_div.sv
// ----------------------------------------------------------------------------
// dtgd_div: bit-serial restoring divider
// Produces one quotient bit per cycle; the dividend shifts out of the top of
// the quotient register as quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module dtgd_div
    import dtgd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [DVS_W:0]     rem_sh;
    logic               ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/distance_to_gamma_dimmer.sv
// ----------------------------------------------------------------------------
// distance_to_gamma_dimmer: moving-average distance to gamma-corrected duty
// Averages the last WINDOW rangefinder samples, maps the mean inversely onto
// an 8-bit brightness between two programmable limits and looks up a 16-bit
// PWM duty in a fixed gamma table.
// ----------------------------------------------------------------------------
// Each input transfer passes through the sequencer states S_AVG, S_BRT
// (only when far_limit is above near_limit) and S_OUT, from acceptance to
// a result in the output register. The single bit-serial divider computes
// the mean (running sum over WINDOW) and then, with ordered limits, the
// brightness quotient; S_OUT loads the output register once it is free.
// The sequencer then returns to idle, so the block takes no new sample
// until the previous one has left the sequencer. A new sample is accepted as
// soon as the sequencer is idle, even while the previous result still waits
// in the output register. The history line starts as zeros after reset, so
// early means include zeros. Limits are written through the APB port at byte
// addresses 0 (near_limit) and 4 (far_limit); the user must write them only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module distance_to_gamma_dimmer
    import dtgd_pkg::*;
#(
    parameter int WINDOW = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    // APB configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // Sample channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SMP_W-1:0]  distance_sample,
    // Result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [SMP_W-1:0]  average_distance,
    output logic [BRT_W-1:0]  brightness_level,
    output logic [DTY_W-1:0]  duty_cycle
);

    localparam int TOT_W = $clog2(1023 * WINDOW + 1);

    // Configuration registers.
    logic [SMP_W-1:0] near_reg, far_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= NEAR_RESET;
            far_reg  <= FAR_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NEAR)
            begin
                near_reg <= pwdata[SMP_W-1:0];
            end
            else
            begin
                far_reg <= pwdata[SMP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_NEAR) ? 32'(near_reg) : 32'(far_reg);

    // Sequencer and datapath registers.
    state_t           state_reg, state_next;
    logic [SMP_W-1:0] hist_reg [WINDOW];
    logic [TOT_W-1:0] total_reg;
    logic [SMP_W-1:0] avg_reg, avg_next;
    logic [BRT_W-1:0] brt_reg, brt_next;
    logic             out_valid_reg;
    logic [SMP_W-1:0] out_avg_reg;
    logic [BRT_W-1:0] out_brt_reg;
    logic [DTY_W-1:0] out_dty_reg;

    logic             in_acc;
    logic             out_free;
    logic             ordered;
    logic             load_out;
    div_req_t         div_req;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [SMP_W-1:0] mean_q;
    logic [SMP_W-1:0] clamped;
    logic [SMP_W-1:0] span;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign ordered  = far_reg > near_reg;
    assign mean_q   = div_quo[SMP_W-1:0];

    // Clamp the fresh mean into the limit window and offset it from near.
    always_comb
    begin
        clamped = mean_q;
        if (mean_q < near_reg)
        begin
            clamped = near_reg;
        end
        if (mean_q > far_reg)
        begin
            clamped = far_reg;
        end
        span = clamped - near_reg;
    end

    // History line and running sum update on each accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                hist_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (in_acc)
        begin
            hist_reg[0] <= distance_sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            total_reg <= total_reg - TOT_W'(hist_reg[WINDOW-1]) + TOT_W'(distance_sample);
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    state_next = ordered ? S_BRT : S_OUT;
                end
            end
            S_BRT:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer: divider requests and result capture.
    always_comb
    begin
        div_req  = '0;
        avg_next = avg_reg;
        brt_next = brt_reg;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    // The registered sum does not yet include this sample, so the
                    // request uses the updated total computed here.
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(total_reg - TOT_W'(hist_reg[WINDOW-1])
                                       + TOT_W'(distance_sample));
                    div_req.divisor  = DVS_W'(WINDOW);
                end
            end
            S_AVG:
            begin
                if (div_done)
                begin
                    avg_next = mean_q;
                    brt_next = FULL_BRIGHT;
                    if (ordered)
                    begin
                        // span * 255 as span * 256 - span.
                        div_req.start    = 1'b1;
                        div_req.dividend = {span, 8'd0} - DVD_W'(span);
                        div_req.divisor  = far_reg - near_reg;
                    end
                end
            end
            S_BRT:
            begin
                if (div_done)
                begin
                    brt_next = FULL_BRIGHT - div_quo[BRT_W-1:0];
                end
            end
            S_OUT:
            begin
                load_out = out_free;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    dtgd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
        brt_reg <= brt_next;
        if (load_out)
        begin
            out_avg_reg <= avg_reg;
            out_brt_reg <= brt_reg;
            out_dty_reg <= GAMMA_ROM[brt_reg];
        end
    end

    assign out_valid        = out_valid_reg;
    assign average_distance = out_avg_reg;
    assign brightness_level = out_brt_reg;
    assign duty_cycle       = out_dty_reg;

    // An accepted sample always starts the mean division.
    a_acc_starts_avg: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_AVG))
        else $error("accepted sample did not start the mean division");

    // The divider only finishes while the sequencer waits for it.
    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_AVG || state_reg == S_BRT))
        else $error("divider finished outside a division state");

    // The brightness division runs only with ordered limits.
    a_brt_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BRT) |-> ordered)
        else $error("brightness division with unordered limits");

    // A new result is loaded only when the output register is free.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a pending transfer");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the distance-to-gamma dimmer
// A short directed stimulus table and about 800 random samples are sent
// through the sample channel. Each accepted sample is run through a local
// model of the moving average, the brightness mapping and the gamma lookup.
// Every result transfer is then compared against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import dtgd_pkg::*;

    localparam int WIN       = 10;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYC   = 400000;

    typedef struct packed {
        logic [SMP_W-1:0] avg;
        logic [BRT_W-1:0] brt;
        logic [DTY_W-1:0] duty;
    } dim_result_t;

    // One row of the directed table. When has_exp is set, the row carries a
    // result that is plain from the spec and is checked in addition to the
    // prediction.
    typedef struct {
        logic [SMP_W-1:0] smp;
        bit               has_exp;
        dim_result_t      exp;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              psel, penable, pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [SMP_W-1:0]  distance_sample;
    logic              out_valid;
    logic              out_stall;
    logic [SMP_W-1:0]  average_distance;
    logic [BRT_W-1:0]  brightness_level;
    logic [DTY_W-1:0]  duty_cycle;

    // Local copy of the block's state and limits.
    logic [SMP_W-1:0]  hist_line [WIN];
    int unsigned       hist_sum;
    logic [SMP_W-1:0]  lim_near, lim_far;

    dim_result_t       pending_results[$];
    dim_result_t       table_checks[$];
    bit                table_has[$];
    int                mismatch_cnt;
    int                cycle_cnt;
    int                send_idle_pct, recv_idle_pct;

    distance_to_gamma_dimmer #(.WINDOW(WIN)) i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shift a sample into the model line and return the expected result.
    function automatic dim_result_t predict_dimmer(logic [SMP_W-1:0] smp);
        dim_result_t r;
        int unsigned x, b;
        hist_sum = hist_sum - hist_line[WIN-1];
        for (int i = WIN - 1; i > 0; i--)
            hist_line[i] = hist_line[i-1];
        hist_line[0] = smp;
        hist_sum = hist_sum + smp;
        r.avg = SMP_W'(hist_sum / WIN);
        if (lim_far <= lim_near)
            b = 255;
        else
        begin
            x = r.avg;
            if (x < lim_near) x = lim_near;
            if (x > lim_far) x = lim_far;
            b = 255 - ((x - lim_near) * 255) / (lim_far - lim_near);
        end
        r.brt  = BRT_W'(b);
        r.duty = GAMMA_ROM[r.brt];
        return r;
    endfunction

    // Idle the sender at random; otherwise present the sample and wait for
    // the transfer. The valid stays high across back-to-back transfers.
    task automatic send_sample(logic [SMP_W-1:0] smp, bit has_exp, dim_result_t exp);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        distance_sample <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(predict_dimmer(smp));
        table_checks.push_back(exp);
        table_has.push_back(has_exp);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let the sequencer return to idle before any register write.
        repeat (50) @(posedge clk);
    endtask

    task automatic write_limit(logic sel, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_NEAR)
            lim_near = val[SMP_W-1:0];
        else
            lim_far = val[SMP_W-1:0];
    endtask

    function automatic void report_field(string fname, int exp_v, int act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("mismatch %s: expected %0d, got %0d", fname, exp_v, act_v);
    endfunction

    // Result checker. Stall is driven at the clock edge, and a transfer is
    // sampled at the same edge from the values that were settled before it.
    always @(posedge clk)
    begin
        dim_result_t e, t;
        bit          h;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_field("unexpected result", 0, 1);
                else
                begin
                    e = pending_results.pop_front();
                    t = table_checks.pop_front();
                    h = table_has.pop_front();
                    if (average_distance !== e.avg)
                        report_field("average_distance", int'(e.avg),
                                     int'(average_distance));
                    if (brightness_level !== e.brt)
                        report_field("brightness_level", int'(e.brt),
                                     int'(brightness_level));
                    if (duty_cycle !== e.duty)
                        report_field("duty_cycle", int'(e.duty), int'(duty_cycle));
                    if (h && (t.avg !== average_distance))
                        report_field("table average_distance", int'(t.avg),
                                     int'(average_distance));
                    if (h && (t.brt !== brightness_level))
                        report_field("table brightness_level", int'(t.brt),
                                     int'(brightness_level));
                    if (h && (t.duty !== duty_cycle))
                        report_field("table duty_cycle", int'(t.duty), int'(duty_cycle));
                end
            end
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Watchdog on a free-running cycle counter.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYC)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic dim_result_t mk(int a, int b);
        dim_result_t r;
        r.avg  = SMP_W'(a);
        r.brt  = BRT_W'(b);
        r.duty = GAMMA_ROM[b];
        return r;
    endfunction

    initial
    begin
        dir_row_t dir_rows[$];
        dim_result_t none;
        logic [SMP_W-1:0] base;
        int phase_len;

        none = '0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        paddr = '0; pwdata = '0;
        in_valid = 1'b0; distance_sample = '0; out_stall = 1'b0;
        mismatch_cnt = 0; cycle_cnt = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < WIN; i++) hist_line[i] = '0;
        hist_sum = 0;
        lim_near = NEAR_RESET;
        lim_far  = FAR_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-up: zeros in the line pull the mean below near, so full
        // brightness; a single full-scale sample lifts the mean just past
        // near. Then saturate the line with full-scale samples, which
        // drives the mean past far and the brightness to zero.
        dir_rows.push_back('{10'd0,    1'b1, mk(0, 255)});
        dir_rows.push_back('{10'd1023, 1'b1, mk(102, 252)});
        for (int i = 0; i < 9; i++)
            dir_rows.push_back('{10'd1023, 1'b0, none});
        dir_rows.push_back('{10'd1023, 1'b1, mk(1023, 0)});
        for (int i = 0; i < 4; i++)
            dir_rows.push_back('{10'd170, 1'b0, none});
        for (int i = 0; i < 6; i++)
            dir_rows.push_back('{SMP_W'(10'h155 ^ (i[0] ? 10'h3ff : 10'h0)), 1'b0, none});
        send_idle_pct = 21; recv_idle_pct = 67;
        foreach (dir_rows[k])
            send_sample(dir_rows[k].smp, dir_rows[k].has_exp, dir_rows[k].exp);
        wait_drained();

        // Random phases with a range of limit settings, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_limit(REG_NEAR, 32'd0);    write_limit(REG_FAR, 32'd1023); end
                1: begin write_limit(REG_NEAR, 32'd500);  write_limit(REG_FAR, 32'd500);  end
                2: begin write_limit(REG_NEAR, 32'd1023); write_limit(REG_FAR, 32'd0);    end
                3: begin write_limit(REG_NEAR, 32'd1022); write_limit(REG_FAR, 32'd1023); end
                4: begin write_limit(REG_NEAR, 32'hFFFF_FC00); write_limit(REG_FAR, 32'd1); end
                default:
                begin
                    write_limit(REG_NEAR, $urandom_range(600, 0) | ($urandom << 10));
                    write_limit(REG_FAR, $urandom_range(1023, 300));
                end
            endcase
            if (ph < 3)      begin send_idle_pct = 21; recv_idle_pct = 67; end
            else if (ph < 6) begin send_idle_pct = 67; recv_idle_pct = 21; end
            else             begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            phase_len = N_RANDOM / 8;
            base = SMP_W'($urandom_range(1023, 0));
            for (int n = 0; n < phase_len; n++)
            begin
                // Mostly samples around a drifting level so the mean walks
                // through the limit band; the rest is full-range noise.
                if ($urandom_range(3, 0) == 0)
                    send_sample(SMP_W'($urandom_range(1023, 0)), 1'b0, none);
                else
                begin
                    base = SMP_W'(int'(base) + $urandom_range(40, 0) - 20);
                    send_sample(base, 1'b0, none);
                end
            end
            wait_drained();
        end

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
